FILE: rtl/cbc_pkg.sv
// Shared types and constants of the cartridge bank controller.
// Used by cbc_map and cartridge_bank_controller; depends on nothing else.
package cbc_pkg;

  localparam int unsigned RomAddrWidth = 23;
  localparam int unsigned RamAddrWidth = 17;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 23;

  localparam logic [CfgIndexWidth-1:0] CfgControllerType = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRomAddressMask = 2'd1;

  localparam logic [1:0] CtrlMbc1 = 2'd0;
  localparam logic [1:0] CtrlMbc3 = 2'd1;
  localparam logic [1:0] CtrlMbc5 = 2'd2;

  localparam logic [RomAddrWidth-1:0] RomMaskReset = 23'h7F_FFFF;
  localparam logic [3:0] RamEnableKey = 4'hA;

  typedef enum logic [1:0] {
    TargetNone = 2'd0,
    TargetRom  = 2'd1,
    TargetRam  = 2'd2,
    TargetCtrl = 2'd3
  } target_e;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } operation_e;

  typedef struct packed {
    operation_e  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    target_e                 target;
    logic [RomAddrWidth-1:0] rom_address;
    logic [RamAddrWidth-1:0] ram_address;
    logic                    ram_write;
    logic                    ram_enabled;
  } resp_t;

  typedef struct packed {
    logic       ram_enable;
    logic [7:0] rom_bank_low;
    logic [1:0] rom_bank_high;
    logic [3:0] ram_bank;
    logic       banking_mode;
  } bank_state_t;

  localparam bank_state_t BankStateReset = '{
    ram_enable:    1'b0,
    rom_bank_low:  8'd1,
    rom_bank_high: 2'd0,
    ram_bank:      4'd0,
    banking_mode:  1'b0
  };

endpackage

FILE: rtl/cbc_map.sv
// Combinational decode of one bus access: control register updates and
// physical ROM and RAM address mapping. Depends on cbc_pkg.
module cbc_map #(
  parameter int unsigned ROM_ADDRESS_BITS = 23,
  parameter int unsigned RAM_ADDRESS_BITS = 17
) (
  input  logic [1:0]                      ctrl_type_i,
  input  logic [cbc_pkg::RomAddrWidth-1:0] rom_mask_i,
  input  cbc_pkg::bank_state_t            state_i,
  input  cbc_pkg::req_t                   req_i,
  output cbc_pkg::bank_state_t            state_o,
  output cbc_pkg::resp_t                  resp_o
);

  localparam logic [cbc_pkg::RomAddrWidth-1:0] RomCut =
    cbc_pkg::RomAddrWidth'((24'(1) << ROM_ADDRESS_BITS) - 24'(1));
  localparam logic [cbc_pkg::RamAddrWidth-1:0] RamCut =
    cbc_pkg::RamAddrWidth'((18'(1) << RAM_ADDRESS_BITS) - 18'(1));

  logic [15:0] addr;
  logic [7:0]  data;
  logic        in_rom_area;
  logic        in_ram_area;
  logic        is_write;
  logic [6:0]  low_mbc3;
  logic [4:0]  low_mbc1;
  logic [cbc_pkg::RomAddrWidth-1:0] rom_phys;

  assign addr        = req_i.address;
  assign data        = req_i.write_data;
  assign is_write    = (req_i.operation == cbc_pkg::OpWrite);
  assign in_rom_area = ~addr[15];
  assign in_ram_area = (addr[15:13] == 3'b101);
  assign low_mbc3    = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
  assign low_mbc1    = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];

  always_comb begin
    state_o = state_i;
    if (in_rom_area && is_write) begin
      if (addr[14:13] == 2'b00) begin
        state_o.ram_enable = (data[3:0] == cbc_pkg::RamEnableKey);
      end else begin
        case (ctrl_type_i)
          cbc_pkg::CtrlMbc5: begin
            if (addr[14:12] == 3'b010) begin
              state_o.rom_bank_low = data;
            end else if (addr[14:12] == 3'b011) begin
              state_o.rom_bank_high = {1'b0, data[0]};
            end else if (addr[14:13] == 2'b10) begin
              state_o.ram_bank = data[3:0];
            end
          end
          cbc_pkg::CtrlMbc3: begin
            if (!addr[14]) begin
              state_o.rom_bank_low  = {1'b0, low_mbc3};
              state_o.rom_bank_high = 2'd0;
            end else if (addr[13] == 1'b0) begin
              if (data < 8'd4) begin
                state_o.ram_bank = {2'b00, data[1:0]};
              end
            end
          end
          default: begin
            if (!addr[14]) begin
              state_o.rom_bank_low = {3'b000, low_mbc1};
            end else if (addr[13] == 1'b0) begin
              if (!state_i.banking_mode) begin
                state_o.rom_bank_high = data[1:0];
              end else begin
                state_o.ram_bank = {2'b00, data[1:0]};
              end
            end else begin
              state_o.banking_mode = data[0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    if (!addr[14]) begin
      rom_phys = {9'd0, addr[13:0]};
    end else begin
      case (ctrl_type_i)
        cbc_pkg::CtrlMbc5: begin
          rom_phys = {state_i.rom_bank_high[0], state_i.rom_bank_low, addr[13:0]} & rom_mask_i;
        end
        cbc_pkg::CtrlMbc3: begin
          rom_phys = {2'b00, state_i.rom_bank_low[6:0], addr[13:0]};
        end
        default: begin
          rom_phys = {2'b00, state_i.rom_bank_high, state_i.rom_bank_low[4:0], addr[13:0]};
        end
      endcase
    end
  end

  always_comb begin
    resp_o             = '0;
    resp_o.ram_enabled = state_o.ram_enable;
    if (in_rom_area) begin
      if (is_write) begin
        resp_o.target = cbc_pkg::TargetCtrl;
      end else begin
        resp_o.target      = cbc_pkg::TargetRom;
        resp_o.rom_address = rom_phys & RomCut;
      end
    end else if (in_ram_area) begin
      resp_o.target      = cbc_pkg::TargetRam;
      resp_o.ram_address = {state_i.ram_bank, addr[12:0]} & RamCut;
      resp_o.ram_write   = is_write & state_i.ram_enable;
    end else begin
      resp_o.target = cbc_pkg::TargetNone;
    end
  end

endmodule

FILE: rtl/cartridge_bank_controller.sv
// Top level of the cartridge bank controller (MBC1, MBC3 and MBC5 rules).
// Depends on cbc_pkg and cbc_map.
//
// A transaction accepted at one clock edge has its result in the output or
// skid register after that edge, and the control registers take their new
// values at the same edge, so a transaction may be accepted on every cycle
// that the input does not stall. A one-entry skid register behind the output
// register lets one further transaction in while a result is stalled; the
// input stalls only when both hold a result. The configuration port is
// always ready and should be written only while no transaction is in flight.
module cartridge_bank_controller #(
  parameter int unsigned ROM_ADDRESS_BITS = 23,
  parameter int unsigned RAM_ADDRESS_BITS = 17
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cbc_pkg::req_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cbc_pkg::resp_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cbc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [cbc_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  logic [1:0]                       ctrl_type_q;
  logic [cbc_pkg::RomAddrWidth-1:0] rom_mask_q;
  cbc_pkg::bank_state_t             state_q;
  cbc_pkg::bank_state_t             state_d;
  cbc_pkg::resp_t                   resp;
  cbc_pkg::resp_t                   out_q;
  cbc_pkg::resp_t                   skid_q;
  logic                             out_valid_q;
  logic                             skid_valid_q;
  logic                             accept;
  logic                             pop;
  logic                             cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign pop         = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cbc_map #(
    .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS),
    .RAM_ADDRESS_BITS (RAM_ADDRESS_BITS)
  ) u_map (
    .ctrl_type_i (ctrl_type_q),
    .rom_mask_i  (rom_mask_q),
    .state_i     (state_q),
    .req_i       (in_data_i),
    .state_o     (state_d),
    .resp_o      (resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_type_q <= cbc_pkg::CtrlMbc1;
      rom_mask_q  <= cbc_pkg::RomMaskReset;
    end else if (cfg_write) begin
      if (cfg_index_i == cbc_pkg::CfgControllerType) begin
        ctrl_type_q <= cfg_data_i[1:0];
      end else if (cfg_index_i == cbc_pkg::CfgRomAddressMask) begin
        rom_mask_q <= cfg_data_i[cbc_pkg::RomAddrWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbc_pkg::BankStateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_q <= resp;
      end else begin
        skid_q <= resp;
      end
    end
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the cartridge bank controller (MBC1, MBC3 and MBC5 rules).
// Depends on cbc_pkg and cartridge_bank_controller; directed table first, then random phases.
// Random input gaps and output stalls; checks use typed rows or a bus decode predictor.
module testbench;

  localparam logic [1:0] CtrlUnused = 2'd3;
  localparam int unsigned CycleLimit = 200000;

  typedef enum logic {
    RowAcc,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    cbc_pkg::req_t                    acc;
    logic [1:0]                       ctrl;
    logic [cbc_pkg::RomAddrWidth-1:0] mask;
    logic                             typed;
    cbc_pkg::resp_t                   want;
  } bus_row_t;

  localparam bus_row_t DirectedRows [28] = '{
    '{RowAcc, '{cbc_pkg::OpRead, 16'h0000, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetRom, 23'h00_0000, 17'h0_0000, 1'b0, 1'b0}},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h7FFF, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetRom, 23'h00_7FFF, 17'h0_0000, 1'b0, 1'b0}},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h8000, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetNone, 23'h00_0000, 17'h0_0000, 1'b0, 1'b0}},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'hFFFF, 8'hFF}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetNone, 23'h00_0000, 17'h0_0000, 1'b0, 1'b0}},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'hBFFF, 8'hFF}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetRam, 23'h00_0000, 17'h0_1FFF, 1'b0, 1'b0}},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h0000, 8'h0A}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetCtrl, 23'h00_0000, 17'h0_0000, 1'b0, 1'b1}},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'hA000, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b1,
      '{cbc_pkg::TargetRam, 23'h00_0000, 17'h0_0000, 1'b1, 1'b1}},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h2000, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h3FFF, 8'hFF}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h4000, 8'h03}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h7FFF, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h6000, 8'h01}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h5FFF, 8'h02}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpRead, 16'hA123, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowCfg, '{cbc_pkg::OpRead, 16'h0000, 8'h00}, cbc_pkg::CtrlMbc3, 23'h7F_FFFF, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h2000, 8'h80}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h4000, 8'h08}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h6000, 8'h01}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h4000, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowCfg, '{cbc_pkg::OpRead, 16'h0000, 8'h00}, cbc_pkg::CtrlMbc5, 23'h03_FFFF, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h2000, 8'hFF}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h3000, 8'h01}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h4000, 8'h0F}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h7FFF, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'hBFFF, 8'h5A}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowCfg, '{cbc_pkg::OpRead, 16'h0000, 8'h00}, CtrlUnused, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpWrite, 16'h1FFF, 8'h0B}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0},
    '{RowAcc, '{cbc_pkg::OpRead, 16'h5555, 8'h00}, cbc_pkg::CtrlMbc1, 23'd0, 1'b0, '0}
  };

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  cbc_pkg::req_t                     in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  cbc_pkg::resp_t                    out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [cbc_pkg::CfgIndexWidth-1:0] cfg_index = cbc_pkg::CfgControllerType;
  logic [cbc_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  cbc_pkg::bank_state_t             banks = cbc_pkg::BankStateReset;
  logic [1:0]                       ctrl_type = cbc_pkg::CtrlMbc1;
  logic [cbc_pkg::RomAddrWidth-1:0] rom_mask = cbc_pkg::RomMaskReset;
  cbc_pkg::resp_t                   decodes_due [$];
  int unsigned                      mismatches = 0;
  int unsigned                      results_seen = 0;
  int unsigned                      burst_left = 0;
  int unsigned                      cycles = 0;
  int unsigned                      stall_left = 0;
  int unsigned                      stall_mode = 0;

  cartridge_bank_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decodes one bus access and updates the predicted bank registers.
  function automatic cbc_pkg::resp_t decode_access(input cbc_pkg::req_t acc);
    cbc_pkg::resp_t res;
    logic [15:0]    a;
    logic [7:0]     d;
    logic [8:0]     bank;
    res = '0;
    res.target = cbc_pkg::TargetNone;
    a = acc.address;
    d = acc.write_data;
    if (a < 16'h8000) begin
      if (acc.operation == cbc_pkg::OpWrite) begin
        res.target = cbc_pkg::TargetCtrl;
        if (a < 16'h2000) begin
          banks.ram_enable = (d[3:0] == cbc_pkg::RamEnableKey);
        end else begin
          case (ctrl_type)
            cbc_pkg::CtrlMbc5: begin
              if (a < 16'h3000) begin
                banks.rom_bank_low = d;
              end else if (a < 16'h4000) begin
                banks.rom_bank_high = {1'b0, d[0]};
              end else if (a < 16'h6000) begin
                banks.ram_bank = d[3:0];
              end
            end
            cbc_pkg::CtrlMbc3: begin
              if (a < 16'h4000) begin
                banks.rom_bank_low = {1'b0, d[6:0]};
                if (banks.rom_bank_low == 8'd0) banks.rom_bank_low = 8'd1;
                banks.rom_bank_high = 2'd0;
              end else if (a < 16'h6000 && d < 8'h04) begin
                banks.ram_bank = {2'b00, d[1:0]};
              end
            end
            default: begin
              if (a < 16'h4000) begin
                banks.rom_bank_low = {3'b000, d[4:0]};
                if (banks.rom_bank_low == 8'd0) banks.rom_bank_low = 8'd1;
              end else if (a < 16'h6000) begin
                if (!banks.banking_mode) banks.rom_bank_high = d[1:0];
                else banks.ram_bank = {2'b00, d[1:0]};
              end else begin
                banks.banking_mode = d[0];
              end
            end
          endcase
        end
      end else begin
        res.target = cbc_pkg::TargetRom;
        if (a < 16'h4000) begin
          res.rom_address = {9'd0, a[13:0]};
        end else begin
          case (ctrl_type)
            cbc_pkg::CtrlMbc5: begin
              bank = {banks.rom_bank_high[0], banks.rom_bank_low};
              res.rom_address = {bank, a[13:0]} & rom_mask;
            end
            cbc_pkg::CtrlMbc3: begin
              bank = {2'b00, banks.rom_bank_low[6:0]};
              res.rom_address = {bank, a[13:0]};
            end
            default: begin
              bank = {2'b00, banks.rom_bank_high, banks.rom_bank_low[4:0]};
              res.rom_address = {bank, a[13:0]};
            end
          endcase
        end
      end
    end else if (a >= 16'hA000 && a < 16'hC000) begin
      res.target = cbc_pkg::TargetRam;
      res.ram_address = {banks.ram_bank, a[12:0]};
      res.ram_write = (acc.operation == cbc_pkg::OpWrite) && banks.ram_enable;
    end
    res.ram_enabled = banks.ram_enable;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] wanted);
    if (mismatches < 100) begin
      $display("mismatch in result %0d: %s is %0h, expected %0h", results_seen, field,
               got, wanted);
    end
    mismatches++;
  endtask

  // The sender idles until every outstanding transaction has produced its result.
  task automatic drain_bus();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (decodes_due.size() != 0);
  endtask

  task automatic program_controller(input logic [1:0] kind,
                                    input logic [cbc_pkg::RomAddrWidth-1:0] mask);
    cfg_valid <= 1'b1;
    cfg_index <= cbc_pkg::CfgControllerType;
    cfg_data <= {21'd0, kind};
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    ctrl_type = kind;
    cfg_index <= cbc_pkg::CfgRomAddressMask;
    cfg_data <= mask;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    rom_mask = mask;
    cfg_valid <= 1'b0;
  endtask

  task automatic issue_access(input cbc_pkg::req_t acc, input logic typed,
                              input cbc_pkg::resp_t typed_res);
    int unsigned    gap;
    cbc_pkg::resp_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= acc;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = decode_access(acc);
    decodes_due.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[1];
    endcase
  end

  always @(posedge clk) begin : check_result
    cbc_pkg::resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decodes_due.size() == 0) begin
        flag_mismatch("unexpected transaction", 32'(out_data), 32'd0);
      end else begin
        want = decodes_due.pop_front();
        if (out_data.target != want.target) begin
          flag_mismatch("target", 32'(out_data.target), 32'(want.target));
        end
        if (out_data.rom_address != want.rom_address) begin
          flag_mismatch("rom_address", 32'(out_data.rom_address), 32'(want.rom_address));
        end
        if (out_data.ram_address != want.ram_address) begin
          flag_mismatch("ram_address", 32'(out_data.ram_address), 32'(want.ram_address));
        end
        if (out_data.ram_write != want.ram_write) begin
          flag_mismatch("ram_write", 32'(out_data.ram_write), 32'(want.ram_write));
        end
        if (out_data.ram_enabled != want.ram_enabled) begin
          flag_mismatch("ram_enabled", 32'(out_data.ram_enabled), 32'(want.ram_enabled));
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    cbc_pkg::req_t                    acc;
    int unsigned                      sel;
    int unsigned                      width;
    logic [cbc_pkg::RomAddrWidth-1:0] mask;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowCfg) begin
        drain_bus();
        program_controller(DirectedRows[i].ctrl, DirectedRows[i].mask);
      end else begin
        issue_access(DirectedRows[i].acc, DirectedRows[i].typed, DirectedRows[i].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      width = $urandom_range(15, 23);
      if (phase == 2) mask = '0;
      else if (phase == 6) mask = cbc_pkg::RomMaskReset;
      else if ($urandom_range(0, 3) == 0) mask = 23'($urandom);
      else mask = 23'((32'd1 << width) - 1);
      drain_bus();
      program_controller(2'(phase), mask);
      for (int n = 0; n < 130; n++) begin
        if (n == 65) drain_bus();
        sel = $urandom_range(0, 99);
        acc.operation = cbc_pkg::operation_e'($urandom_range(0, 1));
        acc.address = 16'($urandom);
        acc.write_data = 8'($urandom);
        if (sel < 40) begin
          acc.operation = cbc_pkg::OpWrite;
          acc.address = {1'b0, 2'($urandom_range(0, 3)), acc.address[12:0]};
          if (acc.address < 16'h2000 && $urandom_range(0, 1) == 1) begin
            acc.write_data[3:0] = cbc_pkg::RamEnableKey;
          end else if ($urandom_range(0, 3) == 0) begin
            acc.write_data = 8'($urandom_range(0, 4));
          end
        end else if (sel < 75) begin
          acc.operation = cbc_pkg::OpRead;
          acc.address[15] = 1'b0;
        end else if (sel < 92) begin
          acc.address[15:13] = 3'b101;
        end
        issue_access(acc, 1'b0, '0);
      end
    end

    drain_bus();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cbc_pkg.sv
rtl/cbc_map.sv
rtl/cartridge_bank_controller.sv
dv/testbench.sv
